// File: hw/rtl/lrup_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrup_pkg;

  // fixed field widths
  localparam int unsigned PAGE_BITS      = 16;
  localparam int unsigned CFG_W          = 5;
  localparam int unsigned SLOT_OUT_W     = 4;
  localparam int unsigned FAULT_W        = 32;
  localparam int unsigned MAX_FRAMES_DEF = 16;
  localparam logic [CFG_W-1:0] FRAMES_RST = CFG_W'(4);

  // command codes
  localparam logic CMD_REF   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // input request
  typedef struct packed {
    logic                 cmd;
    logic [PAGE_BITS-1:0] page_number;
    logic                 last_ref;
  } in_req_t;

  // result
  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] frame_slot;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [FAULT_W-1:0]    fault_total;
    logic                  final_count;
  } out_rsp_t;

  // priority flags rippling along the cell row
  typedef struct packed {
    logic hit;
    logic empty;
    logic lru;
  } prio_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic srch;
    logic upd;
    logic clr;
    logic use_hit;
    logic use_empty;
    logic use_lru;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/lrup_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lrup_cell #(
  parameter int unsigned N      = 16,
  parameter int unsigned IDX    = 0,
  parameter int unsigned RANK_W = 4,
  parameter int unsigned SLOT_W = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lrup_pkg::cell_ctl_t             ctl,
  input  logic                            active,
  input  logic [lrup_pkg::PAGE_BITS-1:0]  req_page,
  input  logic [N-1:0]                    cand_all,
  input  logic [N-1:0][RANK_W-1:0]        rank_all,
  input  logic [RANK_W-1:0]               new_rank,
  input  logic [RANK_W-1:0]               old_rank,
  input  lrup_pkg::prio_t                 prio_i,
  output lrup_pkg::prio_t                 prio_o,
  input  logic [lrup_pkg::PAGE_BITS-1:0]  page_i,
  output logic [lrup_pkg::PAGE_BITS-1:0]  page_o,
  input  logic [RANK_W-1:0]               rank_i,
  output logic [RANK_W-1:0]               rank_o,
  input  logic [SLOT_W-1:0]               slot_i,
  output logic [SLOT_W-1:0]               slot_o,
  output logic                            cand,
  output logic [RANK_W-1:0]               rank
);

  import lrup_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic                 fhit_r, fempty_r, flru_r;
  logic                 match, empty, lower, lru, sel, promote;

  assign cand = valid_r & active;
  assign rank = rank_r;

  // local compare against the request and the other ranks
  always_comb begin
    lower = 1'b0;
    for (int j = 0; j < int'(N); j++) begin
      if (cand_all[j] && (rank_all[j] < rank_r)) begin
        lower = 1'b1;
      end
    end
    match = valid_r & active & (page_r == req_page);
    empty = active & ~valid_r;
    lru   = valid_r & active & ~lower;
  end

  // first-in-row priority handed to the right neighbor
  assign prio_o.hit   = prio_i.hit   | match;
  assign prio_o.empty = prio_i.empty | empty;
  assign prio_o.lru   = prio_i.lru   | lru;

  // selection and data handed along the row
  assign sel     = (ctl.use_hit & fhit_r) | (ctl.use_empty & fempty_r) | (ctl.use_lru & flru_r);
  assign promote = ctl.use_hit | ctl.use_lru;
  assign page_o  = page_i | (sel ? page_r : '0);
  assign rank_o  = rank_i | (sel ? rank_r : '0);
  assign slot_o  = slot_i | (sel ? SLOT_W'(IDX) : '0);

  // frame update
  always_comb begin
    valid_nxt = valid_r;
    page_nxt  = page_r;
    rank_nxt  = rank_r;
    if (ctl.upd) begin
      if (ctl.clr) begin
        valid_nxt = 1'b0;
        page_nxt  = '0;
        rank_nxt  = '0;
      end else if (sel) begin
        valid_nxt = 1'b1;
        page_nxt  = req_page;
        rank_nxt  = new_rank;
      end else if (promote && valid_r && (rank_r > old_rank)) begin
        rank_nxt = rank_r - RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      fhit_r   <= 1'b0;
      fempty_r <= 1'b0;
      flru_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctl.srch) begin
        fhit_r   <= match & ~prio_i.hit;
        fempty_r <= empty & ~prio_i.empty;
        flru_r   <= lru   & ~prio_i.lru;
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    rank_r <= rank_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/lru_page_replacement.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted request is registered, searched in the search state, then its result is written to the output register
// a new request is taken only when idle or as the update state fires, after the search state (page compare and
//   rank compare in every frame cell) and the update state of the cell row for the request before it
// a held result stalls the update state, and with it the next request
// reset (synchronous, rst_n low): table empty, fault count zero, frames_in_use 4

module lru_page_replacement #(
  parameter int unsigned MAX_FRAMES = lrup_pkg::MAX_FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lrup_pkg::in_req_t           in_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lrup_pkg::out_rsp_t          out_rsp,
  input  logic                        cfg_we,
  input  logic [lrup_pkg::CFG_W-1:0]  cfg_wdata
);

  import lrup_pkg::*;

  localparam int unsigned SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned RANK_W = SLOT_W;
  localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SRCH = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  in_req_t              req_r;
  logic [CFG_W-1:0]     frames_r;
  logic [CNT_W-1:0]     vcnt_r, vcnt_nxt;
  logic [FAULT_W-1:0]   faults_r, faults_nxt;
  logic                 any_hit_r, any_empty_r;
  logic                 out_valid_r;
  out_rsp_t             out_r, rsp_nxt;

  logic                 out_free, in_take, upd_fire;
  cell_ctl_t            ctl;
  logic [RANK_W-1:0]    new_rank;

  logic [MAX_FRAMES-1:0]             active;
  logic [MAX_FRAMES-1:0]             cand_all;
  logic [MAX_FRAMES-1:0][RANK_W-1:0] rank_all;
  prio_t                             prio_c [MAX_FRAMES+1];
  logic [PAGE_BITS-1:0]              page_c [MAX_FRAMES+1];
  logic [RANK_W-1:0]                 rank_c [MAX_FRAMES+1];
  logic [SLOT_W-1:0]                 slot_c [MAX_FRAMES+1];

  // handshake
  assign out_free  = ~out_valid_r | ~out_stall;
  assign in_stall  = ~((state_r == ST_IDLE) | ((state_r == ST_UPD) & out_free));
  assign in_take   = in_valid & ~in_stall;
  assign upd_fire  = (state_r == ST_UPD) & out_free;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_SRCH;
      ST_SRCH: state_nxt = ST_UPD;
      ST_UPD: begin
        if (upd_fire) state_nxt = in_take ? ST_SRCH : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // cell control
  always_comb begin
    ctl.srch      = (state_r == ST_SRCH);
    ctl.upd       = upd_fire;
    ctl.clr       = (req_r.cmd == CMD_CLEAR);
    ctl.use_hit   = any_hit_r;
    ctl.use_empty = ~any_hit_r & any_empty_r;
    ctl.use_lru   = ~any_hit_r & ~any_empty_r;
    new_rank      = ctl.use_empty ? RANK_W'(vcnt_r) : RANK_W'(vcnt_r - CNT_W'(1));
  end

  // row of frame cells
  assign prio_c[0] = '0;
  assign page_c[0] = '0;
  assign rank_c[0] = '0;
  assign slot_c[0] = '0;

  for (genvar i = 0; i < int'(MAX_FRAMES); i++) begin : g_cell
    // frame 0 is always in use, so a zero count acts as one
    assign active[i] = (i == 0) || (32'(i) < 32'(frames_r));

    lrup_cell #(
      .N      (MAX_FRAMES),
      .IDX    (i),
      .RANK_W (RANK_W),
      .SLOT_W (SLOT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .active   (active[i]),
      .req_page (req_r.page_number),
      .cand_all (cand_all),
      .rank_all (rank_all),
      .new_rank (new_rank),
      .old_rank (rank_c[MAX_FRAMES]),
      .prio_i   (prio_c[i]),
      .prio_o   (prio_c[i+1]),
      .page_i   (page_c[i]),
      .page_o   (page_c[i+1]),
      .rank_i   (rank_c[i]),
      .rank_o   (rank_c[i+1]),
      .slot_i   (slot_c[i]),
      .slot_o   (slot_c[i+1]),
      .cand     (cand_all[i]),
      .rank     (rank_all[i])
    );
  end

  // counters and result
  always_comb begin
    vcnt_nxt   = vcnt_r;
    faults_nxt = faults_r;
    rsp_nxt    = '0;
    if (ctl.clr) begin
      vcnt_nxt   = '0;
      faults_nxt = '0;
    end else begin
      if (ctl.use_empty) vcnt_nxt = vcnt_r + CNT_W'(1);
      if (!ctl.use_hit && (faults_r != {FAULT_W{1'b1}})) begin
        faults_nxt = faults_r + FAULT_W'(1);
      end
      rsp_nxt.hit           = ctl.use_hit;
      rsp_nxt.frame_slot    = SLOT_OUT_W'(slot_c[MAX_FRAMES]);
      rsp_nxt.evicted_valid = ctl.use_lru;
      rsp_nxt.evicted_page  = ctl.use_lru ? page_c[MAX_FRAMES] : '0;
      rsp_nxt.fault_total   = faults_nxt;
      rsp_nxt.final_count   = req_r.last_ref;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frames_r    <= FRAMES_RST;
      vcnt_r      <= '0;
      faults_r    <= '0;
      any_hit_r   <= 1'b0;
      any_empty_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) frames_r <= cfg_wdata;
      if (ctl.srch) begin
        any_hit_r   <= prio_c[MAX_FRAMES].hit;
        any_empty_r <= prio_c[MAX_FRAMES].empty;
      end
      if (upd_fire) begin
        vcnt_r      <= vcnt_nxt;
        faults_r    <= faults_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) req_r <= in_req;
    if (upd_fire) out_r <= rsp_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/lrup_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lrup_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  lrup_pkg::in_req_t   in_req,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lrup_pkg::out_rsp_t  out_rsp
);

  import lrup_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("result changed while stalled");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.hit |-> !out_rsp.evicted_valid)
    else $error("hit reported an eviction");

  // an eviction is a fault, so the count is nonzero
  a_evict_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.evicted_valid |-> out_rsp.fault_total != '0)
    else $error("eviction without a counted fault");

  // reset drops the result channel
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lru_page_replacement lrup_checker u_lrup_checker (.*);

`default_nettype wire

// File: tb/sv/lrup_frame_checker.sv
`timescale 1ns / 1ps

module lrup_frame_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  lrup_pkg::in_req_t          in_req,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  lrup_pkg::out_rsp_t         out_rsp,
  input  logic                       cfg_we,
  input  logic [lrup_pkg::CFG_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending
);
  import lrup_pkg::*;

  localparam int NF = MAX_FRAMES_DEF;
  localparam logic [FAULT_W-1:0] FAULT_SAT = '1;

  // mirror of the frame table
  logic [PAGE_BITS-1:0] frame_page [NF];
  logic                 frame_live [NF];
  int                   frame_rank [NF];
  logic [FAULT_W-1:0]   faults;
  logic [CFG_W-1:0]     frames_cfg;
  out_rsp_t             expected_rsp [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // empty every frame and zero the fault count
  function automatic void wipe_table();
    for (int i = 0; i < NF; i++) begin
      frame_page[i] = '0;
      frame_live[i] = 1'b0;
      frame_rank[i] = 0;
    end
    faults = '0;
  endfunction

  function automatic int live_frames();
    int n;
    n = 0;
    for (int i = 0; i < NF; i++) begin
      if (frame_live[i]) n++;
    end
    return n;
  endfunction

  // move a live frame to the newest rank, closing the gap it leaves
  function automatic void make_newest(int f);
    int old_rank;
    int n_live;
    old_rank = frame_rank[f];
    n_live = live_frames();
    for (int i = 0; i < NF; i++) begin
      if (frame_live[i] && frame_rank[i] > old_rank) frame_rank[i]--;
    end
    frame_rank[f] = n_live - 1;
  endfunction

  // one request against the table: hit, fill of an empty frame, or lru eviction
  function automatic out_rsp_t lookup_page(in_req_t r);
    out_rsp_t res;
    int       lim;
    int       slot;
    bit       found;
    bit       empty;
    res = '0;
    if (r.cmd == CMD_CLEAR) begin
      wipe_table();
      return res;
    end
    if (frames_cfg == 0) lim = 1;
    else if (frames_cfg > NF) lim = NF;
    else lim = frames_cfg;
    slot = 0;
    found = 1'b0;
    empty = 1'b0;

    // lowest-index active match wins
    for (int i = 0; i < lim; i++) begin
      if (!found && frame_live[i] && frame_page[i] == r.page_number) begin
        slot = i;
        found = 1'b1;
      end
    end

    if (found) begin
      make_newest(slot);
    end else begin
      for (int i = 0; i < lim; i++) begin
        if (!empty && !frame_live[i]) begin
          slot = i;
          empty = 1'b1;
        end
      end
      if (empty) begin
        frame_rank[slot] = live_frames();
        frame_live[slot] = 1'b1;
        frame_page[slot] = r.page_number;
      end else begin
        // all active frames live: take the oldest rank
        slot = 0;
        for (int i = 1; i < lim; i++) begin
          if (frame_rank[i] < frame_rank[slot]) slot = i;
        end
        res.evicted_valid = 1'b1;
        res.evicted_page = frame_page[slot];
        frame_page[slot] = r.page_number;
        make_newest(slot);
      end
      if (faults != FAULT_SAT) faults++;
    end

    res.hit = found;
    res.frame_slot = SLOT_OUT_W'(slot);
    res.fault_total = faults;
    res.final_count = r.last_ref;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [FAULT_W-1:0] want_v,
                                      input logic [FAULT_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // track config writes, predict on each accepted request, compare each result
  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      wipe_table();
      frames_cfg = FRAMES_RST;
      expected_rsp.delete();
    end else begin
      if (cfg_we) frames_cfg = cfg_wdata;
      if (in_valid && !in_stall) expected_rsp.push_back(lookup_page(in_req));
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("result with no request outstanding: %p", out_rsp);
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("hit", want.hit, out_rsp.hit);
          check_field("frame_slot", want.frame_slot, out_rsp.frame_slot);
          check_field("evicted_valid", want.evicted_valid, out_rsp.evicted_valid);
          check_field("evicted_page", want.evicted_page, out_rsp.evicted_page);
          check_field("fault_total", want.fault_total, out_rsp.fault_total);
          check_field("final_count", want.final_count, out_rsp.final_count);
        end
      end
    end
    pending = expected_rsp.size();
  end

endmodule

// File: tb/sv/lru_page_replacement_tb.sv
`timescale 1ns / 1ps

module lru_page_replacement_tb;
  import lrup_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_MAX    = 24;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 75;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_req_t            in_req;
  logic               out_valid;
  logic               out_stall;
  out_rsp_t           out_rsp;
  logic               cfg_we;
  logic [CFG_W-1:0]   cfg_wdata;
  int                 fail_count;
  int                 pending;

  bit                 sender_idles = 1'b1;
  bit                 receiver_stalls = 1'b1;
  int                 hold_len = 0;
  int                 cycle_count = 0;
  logic [PAGE_BITS-1:0] page_pool [POOL_MAX];

  lru_page_replacement i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lrup_frame_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stall bursts, plus a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_stall = 1'b1;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
        out_stall = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  function automatic in_req_t mk_req(logic c, logic [PAGE_BITS-1:0] pg, logic lr);
    return in_req_t'{cmd: c, page_number: pg, last_ref: lr};
  endfunction

  // mostly pages from a small working set so hits and evictions both happen
  function automatic in_req_t pick_request(int pool_n);
    in_req_t r;
    r.cmd = ($urandom_range(0, 99) < 2) ? CMD_CLEAR : CMD_REF;
    if ($urandom_range(0, 99) < 80) r.page_number = page_pool[$urandom_range(0, pool_n - 1)];
    else r.page_number = PAGE_BITS'($urandom);
    r.last_ref = ($urandom_range(0, 9) == 0);
    return r;
  endfunction

  // offer one request, optionally after an idle burst; returns at the next falling edge
  task automatic issue_request(input in_req_t r);
    int gap;
    gap = 0;
    if (sender_idles && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_req = r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_frames(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] cfg_v;
    int               eff;
    int               pool_n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // default four frames: fills, a hit, lru evictions, clear with ignored fields
    issue_request(mk_req(CMD_REF, 16'h0000, 1'b0));
    issue_request(mk_req(CMD_REF, 16'hFFFF, 1'b0));
    issue_request(mk_req(CMD_REF, 16'h0000, 1'b0));
    issue_request(mk_req(CMD_REF, 16'h1234, 1'b0));
    issue_request(mk_req(CMD_REF, 16'h8000, 1'b0));
    issue_request(mk_req(CMD_REF, 16'h5555, 1'b1));
    issue_request(mk_req(CMD_REF, 16'hFFFF, 1'b0));
    issue_request(mk_req(CMD_CLEAR, 16'hABCD, 1'b1));
    issue_request(mk_req(CMD_REF, 16'h0000, 1'b1));

    // frame count zero acts as one
    set_frames(CFG_W'(0));
    issue_request(mk_req(CMD_REF, 16'h0007, 1'b0));
    issue_request(mk_req(CMD_REF, 16'h0007, 1'b0));
    issue_request(mk_req(CMD_REF, 16'h0009, 1'b0));

    // shrink then grow so one page sits in two active frames
    set_frames(CFG_W'(4));
    issue_request(mk_req(CMD_CLEAR, 16'h0000, 1'b0));
    issue_request(mk_req(CMD_REF, 16'h0001, 1'b0));
    issue_request(mk_req(CMD_REF, 16'h0002, 1'b0));
    issue_request(mk_req(CMD_REF, 16'h0003, 1'b0));
    issue_request(mk_req(CMD_REF, 16'h0004, 1'b0));
    set_frames(CFG_W'(2));
    issue_request(mk_req(CMD_REF, 16'h0003, 1'b0));
    set_frames(CFG_W'(4));
    issue_request(mk_req(CMD_REF, 16'h0003, 1'b0));
    issue_request(mk_req(CMD_REF, 16'h0004, 1'b0));

    // frame count above the table size acts as the full table
    set_frames(CFG_W'(31));
    issue_request(mk_req(CMD_REF, 16'hFFFF, 1'b0));
    issue_request(mk_req(CMD_REF, 16'h0000, 1'b1));

    // random phases over a range of frame counts, table carried across
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: cfg_v = CFG_W'(1);
        1: cfg_v = CFG_W'(16);
        2: cfg_v = CFG_W'(0);
        3: cfg_v = CFG_W'(31);
        4: cfg_v = CFG_W'(8);
        5: cfg_v = CFG_W'($urandom_range(2, 15));
        6: cfg_v = CFG_W'(17);
        7: cfg_v = CFG_W'(2);
        8: cfg_v = CFG_W'($urandom_range(0, 31));
        default: cfg_v = CFG_W'(4);
      endcase
      set_frames(cfg_v);
      sender_idles = (p % 3 != 2) && (p != PHASES - 1);
      receiver_stalls = (p % 4 != 3) && (p != PHASES - 1);
      if (p == 1) hold_len = 80;

      if (cfg_v == 0) eff = 1;
      else if (cfg_v > 16) eff = 16;
      else eff = cfg_v;
      pool_n = eff + $urandom_range(1, 4);
      for (int i = 0; i < pool_n; i++) page_pool[i] = PAGE_BITS'($urandom_range(0, 65535));

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == 40) drain_results();
        issue_request(pick_request(pool_n));
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
